// ----- src/ubxfc_pkg.sv -----
package ubxfc_pkg;

  // Sync header bytes
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Header layout: positions within the buffer
  localparam logic [16:0] POS_SYNC1 = 17'd0;
  localparam logic [16:0] POS_SYNC2 = 17'd1;
  localparam logic [16:0] POS_CLASS = 17'd2;
  localparam logic [16:0] POS_ID    = 17'd3;
  localparam logic [16:0] POS_LEN_L = 17'd4;
  localparam logic [16:0] POS_LEN_H = 17'd5;

  // Header plus checksum bytes around the payload
  localparam logic [16:0] FRAME_OVERHEAD = 17'd8;
  localparam logic [16:0] POS_MAX        = 17'h1FFFF;

  localparam logic [15:0] MAX_FRAME_LENGTH_RESET = 16'd1024;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SYNC     = 2'd1,
    ST_LENGTH   = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [16:0] frame_length;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
  } result_t;

endpackage

// ----- src/ubx_frame_checker.sv -----
// Frame checker: one valid buffer byte is taken per cycle when not stalled.
// The result for the last byte is registered in the output or skid register.
// A two-entry output queue (output register plus skid register) keeps input
// flowing while a result waits; input stalls only when both entries are full.
// Synchronous reset clears the frame state and the queue and sets the maximum
// frame length register to 1024.
module ubx_frame_checker
  import ubxfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [16:0] frame_length,
  output logic [7:0]  msg_class,
  output logic [7:0]  msg_id
);

  // Configuration register
  logic [15:0] max_frame_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_FRAME_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_frame_length <= cfg_wr_data;
    end
  end

  // Frame state
  logic [16:0] byte_position, byte_position_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [16:0] declared_length, declared_length_next;
  logic        sync_bad, sync_bad_next;
  logic        check_bad, check_bad_next;
  logic [7:0]  class_byte, class_byte_next;
  logic [7:0]  id_byte, id_byte_next;

  // Output queue
  result_t     out_res, skid_res, new_res;
  logic        skid_valid;

  logic        in_take, push, pop;
  logic [17:0] pos_plus2;
  logic [17:0] pos_plus1;
  logic [17:0] decl_ext;

  assign in_stall  = skid_valid;
  assign in_take   = in_valid && !in_stall;
  assign push      = in_take && last_byte;
  assign pop       = out_valid && !out_stall;

  assign pos_plus2 = {1'b0, byte_position} + 18'd2;
  assign pos_plus1 = {1'b0, byte_position} + 18'd1;
  assign decl_ext  = {1'b0, declared_length_next};

  // Per-byte update of header fields, checksum and error flags
  always_comb begin
    sum_a_next           = sum_a;
    sum_b_next           = sum_b;
    declared_length_next = declared_length;
    sync_bad_next        = sync_bad;
    check_bad_next       = check_bad;
    class_byte_next      = class_byte;
    id_byte_next         = id_byte;

    if (byte_position == POS_SYNC1) begin
      if (data_byte != SYNC_FIRST) sync_bad_next = 1'b1;
    end else if (byte_position == POS_SYNC2) begin
      if (data_byte != SYNC_SECOND) sync_bad_next = 1'b1;
    end else if (byte_position <= POS_LEN_H) begin
      if (byte_position == POS_CLASS) begin
        class_byte_next = data_byte;
      end else if (byte_position == POS_ID) begin
        id_byte_next = data_byte;
      end else if (byte_position == POS_LEN_L) begin
        declared_length_next = {9'd0, data_byte};
      end else begin
        // low byte is already held; add high byte and overhead
        declared_length_next = {1'b0, data_byte, declared_length[7:0]} + FRAME_OVERHEAD;
      end
      sum_a_next = sum_a + data_byte;
      sum_b_next = sum_b + sum_a_next;
    end else begin
      if (pos_plus2 < {1'b0, declared_length}) begin
        sum_a_next = sum_a + data_byte;
        sum_b_next = sum_b + sum_a_next;
      end else if (pos_plus2 == {1'b0, declared_length}) begin
        if (data_byte != sum_a) check_bad_next = 1'b1;
      end else if (pos_plus1 == {1'b0, declared_length}) begin
        if (data_byte != sum_b) check_bad_next = 1'b1;
      end
    end

    // position advances with saturation; cleared after the last byte
    if (byte_position < POS_MAX) begin
      byte_position_next = byte_position + 17'd1;
    end else begin
      byte_position_next = byte_position;
    end
  end

  // Result for a last byte, from the updated state
  always_comb begin
    if (sync_bad_next) begin
      new_res.status = ST_SYNC;
    end else if (byte_position < 17'd7) begin
      new_res.status = ST_LENGTH;
    end else if (declared_length_next >= {1'b0, max_frame_length} ||
                 decl_ext != pos_plus1) begin
      new_res.status = ST_LENGTH;
    end else if (check_bad_next) begin
      new_res.status = ST_CHECKSUM;
    end else begin
      new_res.status = ST_OK;
    end
    new_res.frame_length = (sync_bad_next || byte_position < POS_LEN_H) ?
                           17'd0 : declared_length_next;
    new_res.msg_class    = class_byte_next;
    new_res.msg_id       = id_byte_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_position   <= '0;
      sum_a           <= '0;
      sum_b           <= '0;
      declared_length <= '0;
      sync_bad        <= 1'b0;
      check_bad       <= 1'b0;
      class_byte      <= '0;
      id_byte         <= '0;
    end else if (in_take) begin
      byte_position   <= byte_position_next;
      sum_a           <= sum_a_next;
      sum_b           <= sum_b_next;
      declared_length <= declared_length_next;
      sync_bad        <= sync_bad_next;
      check_bad       <= check_bad_next;
      class_byte      <= class_byte_next;
      id_byte         <= id_byte_next;
    end
  end

  // Output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= new_res;
      end
    end else if (push) begin
      skid_res <= new_res;
    end
  end

  assign status       = out_res.status;
  assign frame_length = out_res.frame_length;
  assign msg_class    = out_res.msg_class;
  assign msg_id       = out_res.msg_id;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("last byte taken but no result queued");

  a_last_clears_pos: assert property (@(posedge clk) disable iff (rst)
    push |=> byte_position == '0)
    else $error("byte position not cleared after last byte");

  a_ok_has_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status == ST_OK) |-> out_res.frame_length >= FRAME_OVERHEAD)
    else $error("ok result with frame length below overhead");

endmodule
